>>> rtl/core/tcpbrb_pkg.sv
// Shared types and constants for the TCP byte ring buffer.
// Operation codes, controller states and the controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcpbrb_pkg;

  localparam int FIELD_W = 13;
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND  = 3'd0,
    MODE_PEEK    = 3'd1,
    MODE_RELEASE = 3'd2,
    MODE_PLACE   = 3'd3,
    MODE_POP     = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LATCH,
    ST_EXEC,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take_item;
    logic seg_latch;
    logic exec;
    logic fetch;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic seg_start;
    logic needs_read;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/tcp_byte_ring_buffer_unit.sv
// Top level of the TCP byte ring buffer: stream ports, controller and datapath.
// Instantiates tcpbrb_ctrl and tcpbrb_datapath; uses tcpbrb_pkg.
//
// Channel  | Direction | Beat contents
// s_axis   | in        | one operation: mode, data_byte, byte_offset, amount, flags
// m_axis   | out       | one result: read_byte, ok, released, fill_count, free_count
//
// An operation runs from the accepting idle state through a cursor set-up state for
// a segment start, the execute state, a fetch state for a peek or pop that reads the
// store (registered store read), and the done state, which loads its result.
// The byte store has one write port and one read port with registered read data.
// A result waits in the output register while the next beat is accepted; the block
// takes input only in its idle state, and holds in done while that register is full.
// Reset is synchronous and clears pointers, counts and handshake state.
`timescale 1ns / 1ps
`default_nettype none

module tcp_byte_ring_buffer_unit
  import tcpbrb_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // mode [2:0], data_byte [10:3], byte_offset [23:11], amount [36:24], zero fill.
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // first_flag [0].
  input  wire logic                  s_axis_tuser,
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // read_byte [7:0], ok [8], released [21:9], fill_count [34:22], free_count [47:35].
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  tcpbrb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  tcpbrb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (s_axis_tdata),
    .in_first (s_axis_tuser),
    .in_last  (s_axis_tlast),
    .out_data (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/core/tcpbrb_ctrl.sv
// Sequencing controller for the TCP byte ring buffer.
// Drives the datapath through cmd_t and owns both stream handshakes; uses tcpbrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpbrb_ctrl
  import tcpbrb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_valid,
  output logic         s_ready,
  output logic         m_valid,
  input  wire logic    m_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   slot_free;

  assign slot_free = !out_valid || m_ready;
  assign m_valid   = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_valid) begin
          state_next = status.seg_start ? ST_LATCH : ST_EXEC;
        end
      end
      ST_LATCH: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = status.needs_read ? ST_FETCH : ST_DONE;
      end
      ST_FETCH: state_next = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A segment start goes through an extra latch state that sets the cursor and budget.
  always_comb begin
    cmd     = '0;
    s_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_ready       = 1'b1;
        cmd.take_item = s_valid;
      end
      ST_LATCH: cmd.seg_latch = 1'b1;
      ST_EXEC:  cmd.exec      = 1'b1;
      ST_FETCH: cmd.fetch     = 1'b1;
      ST_DONE:  cmd.load_out  = slot_free;
      default:  cmd           = '0;
    endcase
  end

  ap_take_then_work: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |=> ((state == ST_EXEC) || (state == ST_LATCH)))
    else $error("accepted beat did not start execution");

  ap_fetch_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> ($past(state) == ST_EXEC))
    else $error("fetch cycle without a preceding execute cycle");

  ap_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result appeared outside the done state");

endmodule

`default_nettype wire

>>> rtl/core/tcpbrb_datapath.sv
// Datapath of the TCP byte ring buffer: item registers, pointers, counts, byte store.
// Follows cmd_t from tcpbrb_ctrl and reports status_t; uses tcpbrb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpbrb_datapath
  import tcpbrb_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire logic                  in_first,
  input  wire logic                  in_last,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;
  localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

  logic [MODE_W-1:0]  mode_q;
  logic [BYTE_W-1:0]  data_q;
  logic [FIELD_W-1:0] off_q;
  logic [FIELD_W-1:0] amt_q;
  logic               first_q;
  logic               last_q;

  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] held;
  logic [PW-1:0] cursor;
  logic [CW-1:0] budget;

  logic               ok_q;
  logic [FIELD_W-1:0] rel_q;
  logic [BYTE_W-1:0]  rbyte_q;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q;
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [PW-1:0]     mem_raddr;

  function automatic logic [PW-1:0] wrap(input logic [EW-1:0] a);
    logic [EW-1:0] r;
    r = (a >= DEPTH_E) ? a - DEPTH_E : a;
    return r[PW-1:0];
  endfunction

  logic [EW-1:0] held_e, off_e, amt_e, free_e, rel_e;
  logic          room, peek_ok, pop_ok, place_ok, seg_ok;
  logic [PW-1:0] peek_addr, rel_ptr, rptr_inc, wptr_inc, cur_inc, seg_cursor;
  logic [CW-1:0] seg_budget;

  always_comb begin
    held_e     = EW'(held);
    off_e      = EW'(off_q);
    amt_e      = EW'(amt_q);
    free_e     = DEPTH_E - held_e;
    rel_e      = (amt_e > held_e) ? held_e : amt_e;
    room       = held_e < DEPTH_E;
    peek_ok    = off_e < held_e;
    pop_ok     = held != '0;
    place_ok   = (budget != '0) && room;
    seg_ok     = off_e <= free_e;
    peek_addr  = wrap(EW'(rptr) + off_e);
    rel_ptr    = wrap(EW'(rptr) + rel_e);
    rptr_inc   = wrap(EW'(rptr) + EW'(1));
    wptr_inc   = wrap(EW'(wptr) + EW'(1));
    cur_inc    = wrap(EW'(cursor) + EW'(1));
    seg_cursor = wrap(EW'(wptr) + off_e);
    seg_budget = CW'(free_e - off_e);
  end

  // seg_start is decoded from the beat on offer, so the controller can branch at acceptance.
  assign status.seg_start  = (in_data[MODE_W-1:0] == MODE_PLACE) && in_first;
  assign status.needs_read = ((mode_q == MODE_PEEK) && peek_ok) ||
                             ((mode_q == MODE_POP) && pop_ok);

  assign mem_we = cmd.exec && (((mode_q == MODE_APPEND) && room) ||
                               ((mode_q == MODE_PLACE) && place_ok));
  assign mem_waddr = (mode_q == MODE_APPEND) ? wptr : cursor;
  assign mem_raddr = (mode_q == MODE_PEEK) ? peek_addr : rptr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= data_q;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      mode_q  <= in_data[2:0];
      data_q  <= in_data[10:3];
      off_q   <= in_data[23:11];
      amt_q   <= in_data[36:24];
      first_q <= in_first;
      last_q  <= in_last;
    end
    if (cmd.exec) begin
      rbyte_q <= '0;
      rel_q   <= (mode_q == MODE_RELEASE) ? FIELD_W'(rel_e) : '0;
      unique case (mode_q)
        MODE_APPEND: ok_q <= room;
        MODE_PEEK:   ok_q <= peek_ok;
        MODE_PLACE:  ok_q <= place_ok;
        MODE_POP:    ok_q <= pop_ok;
        default:     ok_q <= 1'b0;
      endcase
    end
    if (cmd.fetch) begin
      rbyte_q <= mem_q;
    end
    if (cmd.load_out) begin
      out_data <= {FIELD_W'(free_e), FIELD_W'(held), rel_q, ok_q, rbyte_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      held   <= '0;
      cursor <= '0;
      budget <= '0;
    end else if (cmd.seg_latch) begin
      cursor <= seg_ok ? seg_cursor : wptr;
      budget <= seg_ok ? seg_budget : '0;
    end else if (cmd.exec) begin
      unique case (mode_q)
        MODE_APPEND: begin
          if (room) begin
            wptr <= wptr_inc;
            held <= held + CW'(1);
          end
        end
        MODE_PEEK: held <= held;
        MODE_RELEASE: begin
          rptr <= rel_ptr;
          held <= CW'(held_e - rel_e);
        end
        MODE_PLACE: begin
          if (place_ok) begin
            cursor <= cur_inc;
            budget <= budget - CW'(1);
            held   <= held + CW'(1);
          end
          if (last_q) begin
            wptr <= place_ok ? cur_inc : cursor;
          end
        end
        MODE_POP: begin
          if (pop_ok) begin
            rptr <= rptr_inc;
            held <= held - CW'(1);
          end
        end
        default: held <= held;
      endcase
    end
  end

  ap_held_bound: assert property (@(posedge clk) disable iff (rst)
    EW'(held) <= DEPTH_E)
    else $error("fill count beyond the buffer depth");

  ap_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (EW'(wptr) < DEPTH_E) && (EW'(rptr) < DEPTH_E) && (EW'(cursor) < DEPTH_E))
    else $error("pointer outside the buffer");

  ap_release_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (mode_q == MODE_RELEASE)) |=> (held <= $past(held)))
    else $error("release grew the fill count");

endmodule

`default_nettype wire

>>> dv/tb_tcp_byte_ring_buffer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for tcp_byte_ring_buffer_unit: a directed script and random
// operations, with each result beat checked against a byte ring predictor or a pinned row.
// Depends on tcpbrb_pkg and the RTL under rtl/core; reads no files.
module tb_tcp_byte_ring_buffer_unit;
  import tcpbrb_pkg::*;

  localparam int DEPTH = 4096;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS = 450;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BYTE_W-1:0]  data_byte;
    logic [FIELD_W-1:0] byte_offset;
    logic [FIELD_W-1:0] amount;
    logic               first_flag;
    logic               last_flag;
  } ring_op_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               ok;
    logic [FIELD_W-1:0] released;
    logic [FIELD_W-1:0] fill_count;
    logic [FIELD_W-1:0] free_count;
  } ring_res_t;

  typedef struct packed {
    ring_op_t  op;
    logic      pinned;
    ring_res_t want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [BYTE_W-1:0] ring_mirror [DEPTH];
  bit                ring_written [DEPTH];
  int unsigned       wr_ptr = 0;
  int unsigned       rd_ptr = 0;
  int unsigned       held = 0;
  int unsigned       seg_cursor = 0;
  int unsigned       seg_budget = 0;
  int unsigned       peak_held = 0;
  ring_res_t         pending_results [$];
  int                mismatches = 0;
  int                results_seen = 0;
  int                ops_sent = 0;
  int                cycles = 0;
  logic              calm = 1'b0;

  tcp_byte_ring_buffer_unit #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned ring_wrap(input int unsigned a);
    return (a >= DEPTH) ? a - DEPTH : a;
  endfunction

  function automatic ring_res_t apply_ring_op(input ring_op_t op);
    ring_res_t   res;
    int unsigned room;
    int unsigned rel;
    res = '0;
    case (op.mode)
      MODE_APPEND: begin
        if (held < DEPTH) begin
          ring_mirror[wr_ptr] = op.data_byte;
          ring_written[wr_ptr] = 1'b1;
          wr_ptr = ring_wrap(wr_ptr + 1);
          held++;
          res.ok = 1'b1;
        end
      end
      MODE_PEEK: begin
        if (op.byte_offset < held) begin
          res.read_byte = ring_mirror[ring_wrap(rd_ptr + op.byte_offset)];
          res.ok = 1'b1;
        end
      end
      MODE_RELEASE: begin
        rel = (op.amount > held) ? held : op.amount;
        rd_ptr = ring_wrap(rd_ptr + rel);
        held -= rel;
        res.released = FIELD_W'(rel);
      end
      MODE_PLACE: begin
        if (op.first_flag) begin
          room = DEPTH - held;
          if (op.byte_offset <= room) begin
            seg_cursor = ring_wrap(wr_ptr + op.byte_offset);
            seg_budget = room - op.byte_offset;
          end else begin
            seg_cursor = wr_ptr;
            seg_budget = 0;
          end
        end
        if (seg_budget > 0 && held < DEPTH) begin
          ring_mirror[seg_cursor] = op.data_byte;
          ring_written[seg_cursor] = 1'b1;
          seg_cursor = ring_wrap(seg_cursor + 1);
          seg_budget--;
          held++;
          res.ok = 1'b1;
        end
        if (op.last_flag) wr_ptr = seg_cursor;
      end
      MODE_POP: begin
        if (held > 0) begin
          res.read_byte = ring_mirror[rd_ptr];
          rd_ptr = ring_wrap(rd_ptr + 1);
          held--;
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.fill_count = FIELD_W'(held);
    res.free_count = FIELD_W'(DEPTH - held);
    if (held > peak_held) peak_held = held;
    return res;
  endfunction

  function automatic script_row_t script_step(input logic [MODE_W-1:0] mode, input int data,
                                              input int off, input int amt, input bit first,
                                              input bit last, input bit pinned, input int rb,
                                              input bit ok, input int rel, input int fill);
    script_row_t row;
    row.op = '{mode, BYTE_W'(data), FIELD_W'(off), FIELD_W'(amt), first, last};
    row.pinned = pinned;
    row.want = '{BYTE_W'(rb), ok, FIELD_W'(rel), FIELD_W'(fill), FIELD_W'(DEPTH - fill)};
    return row;
  endfunction

  function automatic ring_op_t random_op();
    ring_op_t op;
    op.mode = MODE_W'($urandom_range(0, 4));
    op.data_byte = BYTE_W'($urandom_range(0, 255));
    op.byte_offset = FIELD_W'($urandom_range(0, 8191));
    op.amount = FIELD_W'($urandom_range(0, 8191));
    op.first_flag = 1'($urandom_range(0, 1));
    op.last_flag = 1'($urandom_range(0, 1));
    return op;
  endfunction

  task automatic send_op(input ring_op_t op, input logic pinned, input ring_res_t want);
    ring_res_t res;
    if (!calm && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tdata <= {3'b000, op.amount, op.byte_offset, op.data_byte, op.mode};
    s_axis_tuser <= op.first_flag;
    s_axis_tlast <= op.last_flag;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    res = apply_ring_op(op);
    pending_results.push_back(pinned ? want : res);
    ops_sent++;
  endtask

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want_v,
                             input logic [FIELD_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin
    ring_res_t got;
    ring_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.read_byte = m_axis_tdata[7:0];
      got.ok = m_axis_tdata[8];
      got.released = m_axis_tdata[21:9];
      got.fill_count = m_axis_tdata[34:22];
      got.free_count = m_axis_tdata[47:35];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("Result beat %h arrived with no operation outstanding.", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("read_byte", FIELD_W'(want.read_byte), FIELD_W'(got.read_byte));
        check_field("ok", FIELD_W'(want.ok), FIELD_W'(got.ok));
        check_field("released", want.released, got.released);
        check_field("fill_count", want.fill_count, got.fill_count);
        check_field("free_count", want.free_count, got.free_count);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycles,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    script_row_t script [22];
    ring_op_t    op;
    int          pick;
    int          r;
    int          seg_len;
    int          random_ops;
    foreach (ring_mirror[i]) ring_mirror[i] = '0;
    // The gap that the one-byte offset segment leaves is released unread.
    script = '{
      script_step(MODE_POP,      8'h5A, 0,    0,    0, 0, 1, 0,     0, 0, 0),
      script_step(MODE_PEEK,     8'h00, 0,    0,    0, 0, 1, 0,     0, 0, 0),
      script_step(MODE_RELEASE,  8'h00, 0,    8191, 1, 1, 1, 0,     0, 0, 0),
      script_step(MODE_SPARE_LO, 8'hFF, 8191, 8191, 1, 1, 1, 0,     0, 0, 0),
      script_step(MODE_SPARE_HI, 8'h00, 0,    0,    0, 0, 1, 0,     0, 0, 0),
      script_step(MODE_APPEND,   8'h00, 0,    0,    0, 0, 1, 0,     1, 0, 1),
      script_step(MODE_APPEND,   8'hFF, 8191, 8191, 1, 1, 1, 0,     1, 0, 2),
      script_step(MODE_APPEND,   8'hA5, 0,    0,    0, 0, 0, 0,     0, 0, 0),
      script_step(MODE_PEEK,     8'h00, 2,    0,    0, 0, 0, 0,     0, 0, 0),
      script_step(MODE_PEEK,     8'h00, 3,    0,    0, 0, 1, 0,     0, 0, 3),
      script_step(MODE_PEEK,     8'h00, 4096, 0,    0, 0, 1, 0,     0, 0, 3),
      script_step(MODE_POP,      8'h00, 0,    0,    0, 0, 1, 8'h00, 1, 0, 2),
      script_step(MODE_RELEASE,  8'h00, 0,    1,    0, 0, 0, 0,     0, 0, 0),
      script_step(MODE_PLACE,    8'h3C, 0,    0,    1, 0, 0, 0,     0, 0, 0),
      script_step(MODE_PLACE,    8'hC3, 0,    0,    0, 1, 0, 0,     0, 0, 0),
      script_step(MODE_PEEK,     8'h00, 1,    0,    0, 0, 0, 0,     0, 0, 0),
      script_step(MODE_PLACE,    8'h11, 8191, 0,    1, 1, 1, 0,     0, 0, 3),
      script_step(MODE_PLACE,    8'h22, 4093, 0,    1, 0, 1, 0,     0, 0, 3),
      script_step(MODE_PLACE,    8'h33, 0,    0,    0, 0, 1, 0,     0, 0, 3),
      script_step(MODE_PLACE,    8'h77, 1,    0,    1, 1, 0, 0,     0, 0, 0),
      script_step(MODE_POP,      8'h00, 0,    0,    0, 0, 0, 0,     0, 0, 0),
      script_step(MODE_RELEASE,  8'h00, 0,    4097, 0, 0, 1, 0,     0, 3, 0)
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_op(script[i].op, script[i].pinned, script[i].want);

    // Reads that would land on a byte never stored become an out-of-range peek or a release.
    random_ops = 0;
    while (random_ops < RANDOM_OPS) begin
      calm <= (random_ops >= 150 && random_ops < 270);
      op = random_op();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        op.mode = MODE_PLACE;
        r = $urandom_range(0, 9);
        if (r < 4) op.byte_offset = '0;
        else if (r < 7) op.byte_offset = FIELD_W'($urandom_range(0, 8));
        else if (r < 8) op.byte_offset = FIELD_W'(DEPTH - held);
        else if (r < 9) op.byte_offset = FIELD_W'($urandom_range(0, DEPTH - held));
        seg_len = $urandom_range(1, 6);
        for (int k = 0; k < seg_len; k++) begin
          op.first_flag = (k == 0) && (pick != 0);
          op.last_flag = (k == seg_len - 1);
          send_op(op, 1'b0, '0);
          op.data_byte = BYTE_W'($urandom_range(0, 255));
          op.byte_offset = FIELD_W'($urandom_range(0, 8191));
          random_ops++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (pick < 55) begin
          op.mode = MODE_APPEND;
        end else if (pick < 70) begin
          op.mode = MODE_PEEK;
          if (held > 0 && r < 85) op.byte_offset = FIELD_W'($urandom_range(0, held - 1));
          else if (r < 92) op.byte_offset = FIELD_W'(held);
          if (op.byte_offset < held && !ring_written[ring_wrap(rd_ptr + op.byte_offset)])
            op.byte_offset = FIELD_W'(held);
        end else if (pick < 80) begin
          op.mode = MODE_RELEASE;
          if (r < 70) op.amount = FIELD_W'($urandom_range(0, 6));
          else if (r < 90) op.amount = FIELD_W'($urandom_range(0, held));
          else if (r < 95) op.amount = FIELD_W'(DEPTH + 1);
        end else if (pick < 97) begin
          op.mode = MODE_POP;
          if (held > 0 && !ring_written[rd_ptr]) begin
            op.mode = MODE_RELEASE;
            op.amount = FIELD_W'(1);
          end
        end else begin
          op.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end
        send_op(op, 1'b0, '0);
        if (op.mode <= MODE_POP) random_ops++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d operations (directed script plus random mix), checked %0d result beats.",
             ops_sent, results_seen);
    $display("Fill level peaked at %0d of %0d bytes; %0d field mismatches.", peak_held, DEPTH,
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
